>>> sv/iis_pkg.sv
package iis_pkg;

  localparam int PIX_W       = 8;
  localparam int DATA_W      = 32;
  localparam int CFG_W_BITS  = 13;
  localparam int CFG_H_BITS  = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int MAX_WIDTH_D = 4096;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RST  = 13'd4096;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RST = 16'd4096;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic first_row;
    logic row_end;
    logic frame_end;
  } scan_flags_t;

endpackage

>>> sv/integral_image_sum.sv
// Channel  | Direction | Transaction fields
// in_      | input     | in_pixel
// out_     | output    | out_integral_value, out_row_end, out_frame_end
// APB      | input     | image_width at 0x0, image_height at 0x4
//
// One pixel per clock when not stalled; stage one feeds the output register.
// Line store: one read at acceptance, one write-back as stage one advances; the
// previous pixel's result is forwarded when both hit the same column.
// Synchronous active-low reset clears counters and valids; line store is not cleared.
// out_stall on a valid output holds it and stage one; in_stall rises only then.
module integral_image_sum
  import iis_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_integral_value,
  output logic                  out_row_end,
  output logic                  out_frame_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int RSUM_W = PIX_W + AW;

  logic [CFG_W_BITS-1:0] width_r;
  logic [CFG_H_BITS-1:0] height_r;
  logic                  adv;
  logic                  accept;
  logic [AW-1:0]         col;
  logic [RSUM_W-1:0]     rsum;
  scan_flags_t           flags;
  logic [DATA_W-1:0]     rd_data;

  logic                  s1_valid_r;
  logic [AW-1:0]         s1_col_r;
  logic [RSUM_W-1:0]     s1_rsum_r;
  scan_flags_t           s1_flags_r;
  logic                  fwd_r;
  logic [DATA_W-1:0]     fwd_data_r;
  logic [DATA_W-1:0]     above;
  logic [DATA_W-1:0]     s1_value;

  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_value_r;
  logic                  out_row_end_r;
  logic                  out_frame_end_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  iis_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_r  (width_r),
    .height_r (height_r)
  );

  iis_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW),
    .RSUM_W    (RSUM_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .pixel    (in_pixel),
    .width_r  (width_r),
    .height_r (height_r),
    .col      (col),
    .rsum     (rsum),
    .flags    (flags)
  );

  iis_line_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_mem (
    .clk     (clk),
    .we      (adv && s1_valid_r),
    .waddr   (s1_col_r),
    .wdata   (s1_value),
    .re      (accept),
    .raddr   (col),
    .rdata_r (rd_data)
  );

  assign above    = s1_flags_r.first_row ? '0 : (fwd_r ? fwd_data_r : rd_data);
  assign s1_value = DATA_W'(s1_rsum_r) + above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= col;
      s1_rsum_r  <= rsum;
      s1_flags_r <= flags;
      fwd_r      <= s1_valid_r && (s1_col_r == col);
      fwd_data_r <= s1_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_value_r     <= s1_value;
      out_row_end_r   <= s1_flags_r.row_end;
      out_frame_end_r <= s1_flags_r.frame_end;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_integral_value = out_value_r;
  assign out_row_end        = out_row_end_r;
  assign out_frame_end      = out_frame_end_r;

endmodule

>>> sv/iis_cfg.sv
module iis_cfg
  import iis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_W_BITS-1:0] width_r,
  output logic [CFG_H_BITS-1:0] height_r
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_r  <= pwdata[CFG_W_BITS-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DATA_W'(width_r);
      REG_HEIGHT: prdata = APB_DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

endmodule

>>> sv/iis_scan.sv
module iis_scan
  import iis_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_D,
  parameter int AW        = $clog2(MAX_WIDTH),
  parameter int RSUM_W    = PIX_W + AW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [PIX_W-1:0]      pixel,
  input  logic [CFG_W_BITS-1:0] width_r,
  input  logic [CFG_H_BITS-1:0] height_r,
  output logic [AW-1:0]         col,
  output logic [RSUM_W-1:0]     rsum,
  output scan_flags_t           flags
);

  logic [AW-1:0]         col_r, col_nxt;
  logic [RSUM_W-1:0]     rsum_r, rsum_nxt;
  logic [CFG_H_BITS-1:0] row_r, row_nxt;
  logic [31:0]           w32;
  logic [31:0]           wm1;
  logic [CFG_H_BITS-1:0] last_row;
  logic                  row_end;
  logic                  frame_end;

  assign w32      = 32'(width_r);
  assign wm1      = (w32 == 32'd0) ? 32'd0 :
                    (w32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : (w32 - 32'd1);
  assign last_row = height_r - CFG_H_BITS'(1);
  assign row_end  = 32'(col_r) >= wm1;
  assign frame_end = row_end && (row_r >= last_row);

  assign col  = col_r;
  assign rsum = rsum_r + RSUM_W'(pixel);
  assign flags = '{first_row: (row_r == '0), row_end: row_end, frame_end: frame_end};

  always_comb begin
    col_nxt  = col_r;
    rsum_nxt = rsum_r;
    row_nxt  = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt  = '0;
        rsum_nxt = '0;
        row_nxt  = frame_end ? '0 : row_r + CFG_H_BITS'(1);
      end else begin
        col_nxt  = col_r + AW'(1);
        rsum_nxt = rsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rsum_r <= '0;
      row_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      rsum_r <= rsum_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

>>> sv/iis_line_mem.sv
module iis_line_mem
  import iis_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_D,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> sv/iis_checker.sv
module iis_checker
  import iis_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_integral_value,
  input logic              out_row_end,
  input logic              out_frame_end
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  a_stall_only_when_full: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_integral_value)
      && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled transaction changed");

endmodule

bind integral_image_sum iis_checker u_iis_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_integral_value (out_integral_value),
  .out_row_end        (out_row_end),
  .out_frame_end      (out_frame_end)
);
